FILE: design/dapid_pkg.sv
// Shared types, constants and the controller microprogram for the dual-axis PID block.
// No dependencies; imported by dapid_core and the top level.
`default_nettype none

package dapid_pkg;

   localparam int CONTROL_HZ_DEF = 50;
   localparam int ANGLE_BITS_DEF = 16;

   localparam int GAIN_W     = 16;
   localparam int TOL_W      = 15;
   localparam int IN_ANGLE_W = 16;
   localparam int DRIVE_W    = 32;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;

   // datapath widths, bounded independently of angle width and rate
   localparam int MUL_A_W  = 32;  // pi, gains, reciprocal, quotient, kd*rate
   localparam int KDHZ_W   = 31;  // kd * rate fits within 31 bits signed
   localparam int RAD_E_W  = 19;  // error in radians Q16
   localparam int RAD_D_W  = 20;  // error difference in radians Q16
   localparam int MAG_W    = 18;  // magnitude of the scaled integral step
   localparam int INTEG_W  = 18;  // integrator, held within +-1 rad
   localparam int ACC_W    = 40;  // P + I + D sum
   localparam int INTEG_LIM = 65536;

   localparam logic [MUL_A_W-1:0] PI_Q29 = 32'd1686629713;

   localparam logic signed [GAIN_W-1:0] ROLL_P_RST = 16'sd4096;
   localparam logic signed [GAIN_W-1:0] ROLL_I_RST = 16'sd41;
   localparam logic signed [GAIN_W-1:0] ROLL_D_RST = 16'sd410;
   localparam logic signed [GAIN_W-1:0] YAW_P_RST  = 16'sd3277;
   localparam logic signed [GAIN_W-1:0] YAW_I_RST  = 16'sd41;
   localparam logic signed [GAIN_W-1:0] YAW_D_RST  = 16'sd410;
   localparam logic [TOL_W-1:0]         ROLL_TOL_RST = 15'd522;
   localparam logic [TOL_W-1:0]         YAW_TOL_RST  = 15'd907;

   typedef enum logic [1:0] {
      CMD_ROLL = 2'd0,
      CMD_YAW  = 2'd1,
      CMD_REF  = 2'd2,
      CMD_TICK = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_ROLL_P   = 3'd0,
      REG_ROLL_I   = 3'd1,
      REG_ROLL_D   = 3'd2,
      REG_YAW_P    = 3'd3,
      REG_YAW_I    = 3'd4,
      REG_YAW_D    = 3'd5,
      REG_ROLL_TOL = 3'd6,
      REG_YAW_TOL  = 3'd7
   } reg_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] ki;
      logic signed [GAIN_W-1:0] kd;
      logic [TOL_W-1:0]         tol;
   } axis_cfg_type;

   typedef struct packed {
      logic start;     // tick accepted with all sources present
      logic out_full;  // result register occupied and not being taken
   } core_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;      // both drives ready this cycle
   } core_stat_type;

   // microprogram fields
   typedef enum logic [2:0] {
      A_NONE, A_PI, A_KD, A_KP, A_KI, A_RECIP, A_QUO, A_KDHZ
   } a_sel_type;

   typedef enum logic [2:0] {
      B_NONE, B_HZ, B_ERR, B_DIF, B_MAG, B_EQ, B_DQ, B_INTEG
   } b_sel_type;

   typedef enum logic [3:0] {
      P_NOP, P_LOAD, P_KDHZ, P_EQ, P_DQ, P_QUO, P_PTERM, P_INTEG, P_ADD, P_WEIGH
   } post_type;

   typedef enum logic {
      J_NEXT, J_AXIS
   } jump_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      post_type  post;
      jump_type  jump;
   } uword_type;

   localparam int STEP_W = 4;

   // Steps 0 to 7 feed the multiplier; steps 1 to 8 consume the product of the step before.
   function automatic uword_type ucode(input logic [STEP_W-1:0] step);
      uword_type w;
      case (step)
         4'd0: w = '{A_KD,    B_HZ,    P_LOAD,  J_NEXT};
         4'd1: w = '{A_PI,    B_ERR,   P_KDHZ,  J_NEXT};
         4'd2: w = '{A_PI,    B_DIF,   P_EQ,    J_NEXT};
         4'd3: w = '{A_RECIP, B_MAG,   P_DQ,    J_NEXT};
         4'd4: w = '{A_KP,    B_EQ,    P_QUO,   J_NEXT};
         4'd5: w = '{A_QUO,   B_HZ,    P_PTERM, J_NEXT};
         4'd6: w = '{A_KDHZ,  B_DQ,    P_INTEG, J_NEXT};
         4'd7: w = '{A_KI,    B_INTEG, P_ADD,   J_NEXT};
         4'd8: w = '{A_NONE,  B_NONE,  P_ADD,   J_NEXT};
         4'd9: w = '{A_NONE,  B_NONE,  P_WEIGH, J_AXIS};
         default: w = '{A_NONE, B_NONE, P_NOP, J_NEXT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: design/dapid_core.sv
// Microcoded PID engine: step counter, ROM from dapid_pkg, one shared multiplier,
// integrators and last errors for both axes. Depends on dapid_pkg.
`default_nettype none

module dapid_core #(
   parameter int CONTROL_HZ = dapid_pkg::CONTROL_HZ_DEF,
   parameter int ANGLE_BITS = dapid_pkg::ANGLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dapid_pkg::core_ctrl_type               ctrl,
   input  dapid_pkg::axis_cfg_type                roll_cfg,
   input  dapid_pkg::axis_cfg_type                yaw_cfg,
   input  logic signed [ANGLE_BITS-1:0]           roll_measured,
   input  logic signed [ANGLE_BITS-1:0]           yaw_measured,
   input  logic signed [ANGLE_BITS-1:0]           roll_target,
   input  logic signed [ANGLE_BITS-1:0]           yaw_target,
   output dapid_pkg::core_stat_type               stat,
   output logic signed [dapid_pkg::DRIVE_W-1:0]   roll_drive,
   output logic signed [dapid_pkg::DRIVE_W-1:0]   yaw_drive
);
   import dapid_pkg::*;

   localparam int MUL_B_W = (ANGLE_BITS + 1 > RAD_D_W) ? ANGLE_BITS + 1 : RAD_D_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int RAD_SH  = ANGLE_BITS + 12;
   localparam int RECIP   = (1 << MAG_W) / CONTROL_HZ;
   localparam int CMP_W   = ((ANGLE_BITS > TOL_W) ? ANGLE_BITS : TOL_W) + 2;
   localparam int ISUM_W  = INTEG_W + 3;
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (RAD_SH - 1);
   localparam logic signed [ISUM_W-1:0] ILIM = ISUM_W'(INTEG_LIM);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type              state_ff, state_in;
   logic                   axis_ff, axis_in;
   logic [STEP_W-1:0]      step_ff, step_in;

   logic signed [ANGLE_BITS-1:0] err_ff, err_in;
   logic signed [ANGLE_BITS:0]   dif_ff, dif_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [KDHZ_W-1:0]     kdhz_ff;
   logic signed [RAD_E_W-1:0]    eq_ff;
   logic signed [RAD_D_W-1:0]    dq_ff;
   logic [MAG_W-1:0]             mag_ff, mag_in;
   logic                         neg_ff;
   logic [MAG_W-1:0]             quo_ff, quo_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [DRIVE_W-1:0]    roll_res_ff;
   logic signed [INTEG_W-1:0]    integ_ff [2];
   logic signed [INTEG_W-1:0]    integ_in;
   logic signed [ANGLE_BITS-1:0] last_ff [2];

   uword_type                  uw;
   axis_cfg_type               cfg;
   logic                       final_step, adv;
   logic signed [MUL_A_W-1:0]  a_op;
   logic signed [MUL_B_W-1:0]  b_op;
   logic signed [PROD_W-1:0]   rnd, pshift;
   logic [PROD_W-1:0]          abs_prod, mag_shift, quo_shift;
   logic [MAG_W:0]             rem, q_mag;
   logic signed [MAG_W+1:0]    q_ext, q_signed;
   logic signed [ISUM_W-1:0]   isum;
   logic signed [CMP_W-1:0]    err_wide;
   logic [CMP_W-1:0]           abs_err, tol_w;
   logic                       above, far;
   logic signed [ACC_W:0]      w_val;
   logic [ACC_W-DRIVE_W+1:0]   upper;
   logic signed [DRIVE_W-1:0]  drive_in;

   assign uw         = ucode(step_ff);
   assign cfg        = axis_ff ? yaw_cfg : roll_cfg;
   assign final_step = (uw.jump == J_AXIS) && axis_ff;
   assign adv        = (state_ff == ST_RUN) && !(final_step && ctrl.out_full);

   // operand selection and shared multiplier
   always_comb begin
      case (uw.a_sel)
         A_PI:    a_op = $signed(PI_Q29);
         A_KD:    a_op = MUL_A_W'(cfg.kd);
         A_KP:    a_op = MUL_A_W'(cfg.kp);
         A_KI:    a_op = MUL_A_W'(cfg.ki);
         A_RECIP: a_op = $signed(MUL_A_W'(RECIP));
         A_QUO:   a_op = $signed(MUL_A_W'(quo_ff));
         A_KDHZ:  a_op = MUL_A_W'(kdhz_ff);
         default: a_op = '0;
      endcase
      case (uw.b_sel)
         B_HZ:    b_op = $signed(MUL_B_W'(CONTROL_HZ));
         B_ERR:   b_op = MUL_B_W'(err_ff);
         B_DIF:   b_op = MUL_B_W'(dif_ff);
         B_MAG:   b_op = $signed(MUL_B_W'(mag_ff));
         B_EQ:    b_op = MUL_B_W'(eq_ff);
         B_DQ:    b_op = MUL_B_W'(dq_ff);
         B_INTEG: b_op = MUL_B_W'(integ_ff[axis_ff]);
         default: b_op = '0;
      endcase
   end

   assign prod_in = a_op * b_op;

   // error and its unwrapped change for the current axis
   assign err_in = axis_ff ? (yaw_target - yaw_measured) : (roll_target - roll_measured);
   assign dif_in = (ANGLE_BITS + 1)'(err_in) - (ANGLE_BITS + 1)'(last_ff[axis_ff]);

   // angle to radians Q16, rounded half up
   assign rnd       = (prod_ff + HALF) >>> RAD_SH;
   assign abs_prod  = prod_ff[PROD_W-1] ? $unsigned(-prod_ff) : $unsigned(prod_ff);
   assign mag_shift = abs_prod >> RAD_SH;
   assign mag_in    = mag_shift[MAG_W-1:0];
   assign quo_shift = $unsigned(prod_ff) >> MAG_W;
   assign quo_in    = quo_shift[MAG_W-1:0];
   assign pshift    = prod_ff >>> 12;

   // reciprocal quotient is low by at most one: fix with one compare
   assign rem      = (MAG_W + 1)'(mag_ff) - prod_ff[MAG_W:0];
   assign q_mag    = (rem >= (MAG_W + 1)'(CONTROL_HZ)) ?
                     (MAG_W + 1)'(quo_ff) + (MAG_W + 1)'(1) : (MAG_W + 1)'(quo_ff);
   assign q_ext    = $signed({1'b0, q_mag});
   assign q_signed = neg_ff ? -q_ext : q_ext;
   assign isum     = ISUM_W'(integ_ff[axis_ff]) + ISUM_W'(q_signed);

   always_comb begin
      if (isum > ILIM) begin
         integ_in = INTEG_W'(ILIM);
      end else if (isum < -ILIM) begin
         integ_in = INTEG_W'(-ILIM);
      end else begin
         integ_in = isum[INTEG_W-1:0];
      end
   end

   always_comb begin
      case (uw.post)
         P_PTERM: acc_in = pshift[ACC_W-1:0];
         P_ADD:   acc_in = acc_ff + pshift[ACC_W-1:0];
         default: acc_in = acc_ff;
      endcase
   end

   // dead band weighting and saturation
   assign err_wide = CMP_W'(err_ff);
   assign abs_err  = err_wide[CMP_W-1] ? $unsigned(-err_wide) : $unsigned(err_wide);
   assign tol_w    = CMP_W'(cfg.tol);
   assign above    = abs_err > tol_w;
   assign far      = (abs_err << 1) > (tol_w + (tol_w << 1));

   always_comb begin
      if (!above) begin
         w_val = '0;
      end else if (far) begin
         w_val = (ACC_W + 1)'(acc_ff) <<< 1;
      end else begin
         w_val = (ACC_W + 1)'(acc_ff);
      end
      upper = w_val[ACC_W:DRIVE_W-1];
      if ((&upper) || !(|upper)) begin
         drive_in = w_val[DRIVE_W-1:0];
      end else if (w_val[ACC_W]) begin
         drive_in = {1'b1, {(DRIVE_W - 1){1'b0}}};
      end else begin
         drive_in = {1'b0, {(DRIVE_W - 1){1'b1}}};
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      step_in  = step_ff;
      if (state_ff == ST_IDLE) begin
         if (ctrl.start) begin
            state_in = ST_RUN;
            axis_in  = 1'b0;
            step_in  = '0;
         end
      end else if (adv) begin
         if (uw.jump == J_AXIS) begin
            step_in = '0;
            if (axis_ff) begin
               state_in = ST_IDLE;
            end else begin
               axis_in = 1'b1;
            end
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         step_ff  <= step_in;
      end
   end

   // controller state kept across ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff[0] <= '0;
         integ_ff[1] <= '0;
         last_ff[0]  <= '0;
         last_ff[1]  <= '0;
      end else if (adv) begin
         if (uw.post == P_INTEG) begin
            integ_ff[axis_ff] <= integ_in;
         end
         if (uw.post == P_WEIGH) begin
            last_ff[axis_ff] <= err_ff;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
         case (uw.post)
            P_LOAD: begin
               err_ff <= err_in;
               dif_ff <= dif_in;
            end
            P_KDHZ: kdhz_ff <= prod_ff[KDHZ_W-1:0];
            P_EQ: begin
               eq_ff  <= rnd[RAD_E_W-1:0];
               mag_ff <= mag_in;
               neg_ff <= prod_ff[PROD_W-1];
            end
            P_DQ:  dq_ff  <= rnd[RAD_D_W-1:0];
            P_QUO: quo_ff <= quo_in;
            P_WEIGH: begin
               if (!axis_ff) begin
                  roll_res_ff <= drive_in;
               end
            end
            default: ;
         endcase
      end
   end

   assign stat.busy  = (state_ff == ST_RUN);
   assign stat.done  = adv && final_step;
   assign roll_drive = roll_res_ff;
   assign yaw_drive  = drive_in;

endmodule

`default_nettype wire

FILE: design/dual_axis_pid_with_error_weighting_top.sv
// Top level of the dual-axis PID: stream channels, APB register file, angle stores.
// Depends on dapid_pkg and dapid_core.
//
//   channel   direction   handshake           payload
//   req_      in          tvalid/tready       tuser: cmd; tdata: angle_a, angle_b
//   rsp_      out         tvalid/tready       tdata: roll_drive, yaw_drive
//   csr_      in          psel/penable        8 registers at 4*i, 32-bit data
//
// Sample and reference transactions are taken whenever the core is idle. A tick with
// all sources present runs two passes (roll, then yaw) of a 10-step microprogram that
// shares one multiplier; input is not taken during that run.
// Reset is synchronous and restores register defaults, clears stores and integrators.
// The result register holds under back-pressure; a following tick waits at its last
// step until the previous result has been taken.
`default_nettype none

module dual_axis_pid_with_error_weighting_top #(
   parameter int CONTROL_HZ = dapid_pkg::CONTROL_HZ_DEF,
   parameter int ANGLE_BITS = dapid_pkg::ANGLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // angle_a [15:0], angle_b [31:16]
   input  logic [1:0]                     req_tuser,   // cmd [1:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,   // roll_drive [31:0], yaw_drive [63:32]
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dapid_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [dapid_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [dapid_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                           csr_pready
);
   import dapid_pkg::*;

   logic signed [GAIN_W-1:0] roll_p_ff, roll_i_ff, roll_d_ff;
   logic signed [GAIN_W-1:0] yaw_p_ff, yaw_i_ff, yaw_d_ff;
   logic [TOL_W-1:0]         roll_tol_ff, yaw_tol_ff;

   logic signed [ANGLE_BITS-1:0] roll_meas_ff, yaw_meas_ff, roll_tgt_ff, yaw_tgt_ff;
   logic [2:0]                   seen_ff, seen_in;
   logic                         rsp_valid_ff;
   logic [63:0]                  rsp_data_ff;

   logic                         csr_wr;
   reg_type                      csr_idx;
   logic                         req_acc;
   cmd_type                      cmd;
   logic signed [IN_ANGLE_W-1:0] in_a, in_b;
   logic signed [ANGLE_BITS-1:0] angle_a, angle_b;

   core_ctrl_type                ctrl;
   core_stat_type                stat;
   axis_cfg_type                 roll_cfg, yaw_cfg;
   logic signed [DRIVE_W-1:0]    roll_drive, yaw_drive;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_p_ff   <= ROLL_P_RST;
         roll_i_ff   <= ROLL_I_RST;
         roll_d_ff   <= ROLL_D_RST;
         yaw_p_ff    <= YAW_P_RST;
         yaw_i_ff    <= YAW_I_RST;
         yaw_d_ff    <= YAW_D_RST;
         roll_tol_ff <= ROLL_TOL_RST;
         yaw_tol_ff  <= YAW_TOL_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ROLL_P:   roll_p_ff   <= csr_pwdata[GAIN_W-1:0];
            REG_ROLL_I:   roll_i_ff   <= csr_pwdata[GAIN_W-1:0];
            REG_ROLL_D:   roll_d_ff   <= csr_pwdata[GAIN_W-1:0];
            REG_YAW_P:    yaw_p_ff    <= csr_pwdata[GAIN_W-1:0];
            REG_YAW_I:    yaw_i_ff    <= csr_pwdata[GAIN_W-1:0];
            REG_YAW_D:    yaw_d_ff    <= csr_pwdata[GAIN_W-1:0];
            REG_ROLL_TOL: roll_tol_ff <= csr_pwdata[TOL_W-1:0];
            REG_YAW_TOL:  yaw_tol_ff  <= csr_pwdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ROLL_P:   csr_prdata = CSR_DW'(roll_p_ff);
         REG_ROLL_I:   csr_prdata = CSR_DW'(roll_i_ff);
         REG_ROLL_D:   csr_prdata = CSR_DW'(roll_d_ff);
         REG_YAW_P:    csr_prdata = CSR_DW'(yaw_p_ff);
         REG_YAW_I:    csr_prdata = CSR_DW'(yaw_i_ff);
         REG_YAW_D:    csr_prdata = CSR_DW'(yaw_d_ff);
         REG_ROLL_TOL: csr_prdata = CSR_DW'(roll_tol_ff);
         REG_YAW_TOL:  csr_prdata = CSR_DW'(yaw_tol_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // input transactions
   assign req_tready = !stat.busy;
   assign req_acc    = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign in_a       = req_tdata[IN_ANGLE_W-1:0];
   assign in_b       = req_tdata[2*IN_ANGLE_W-1:IN_ANGLE_W];
   assign angle_a    = ANGLE_BITS'(in_a);
   assign angle_b    = ANGLE_BITS'(in_b);

   always_comb begin
      seen_in = seen_ff;
      if (req_acc) begin
         case (cmd)
            CMD_ROLL: seen_in = seen_ff | 3'b001;
            CMD_YAW:  seen_in = seen_ff | 3'b010;
            CMD_REF:  seen_in = seen_ff | 3'b100;
            default:  seen_in = seen_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_meas_ff <= '0;
         yaw_meas_ff  <= '0;
         roll_tgt_ff  <= '0;
         yaw_tgt_ff   <= '0;
         seen_ff      <= '0;
      end else begin
         seen_ff <= seen_in;
         if (req_acc) begin
            case (cmd)
               CMD_ROLL: roll_meas_ff <= angle_a;
               CMD_YAW:  yaw_meas_ff  <= angle_a;
               CMD_REF: begin
                  roll_tgt_ff <= angle_a;
                  yaw_tgt_ff  <= angle_b;
               end
               default: ;
            endcase
         end
      end
   end

   // a tick before every source has arrived is dropped
   assign ctrl.start    = req_acc && (cmd == CMD_TICK) && (seen_ff == 3'b111);
   assign ctrl.out_full = rsp_valid_ff && !rsp_tready;

   assign roll_cfg = '{kp: roll_p_ff, ki: roll_i_ff, kd: roll_d_ff, tol: roll_tol_ff};
   assign yaw_cfg  = '{kp: yaw_p_ff,  ki: yaw_i_ff,  kd: yaw_d_ff,  tol: yaw_tol_ff};

   dapid_core #(
      .CONTROL_HZ (CONTROL_HZ),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .roll_cfg      (roll_cfg),
      .yaw_cfg       (yaw_cfg),
      .roll_measured (roll_meas_ff),
      .yaw_measured  (yaw_meas_ff),
      .roll_target   (roll_tgt_ff),
      .yaw_target    (yaw_tgt_ff),
      .stat          (stat),
      .roll_drive    (roll_drive),
      .yaw_drive     (yaw_drive)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_data_ff <= {yaw_drive, roll_drive};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: tb/pid_drive_checker.sv
// Checker for the dual-axis PID block: watches the request, result and register ports,
// predicts the roll and yaw drives and compares them with what the block returns.
// Depends on dapid_pkg for the command and register codes.
`timescale 1ns / 1ps

module pid_drive_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // angle_a [15:0], angle_b [31:16]
   input  logic [1:0]                     req_tuser,   // cmd [1:0]
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [63:0]                    rsp_tdata,   // roll_drive [31:0], yaw_drive [63:32]
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dapid_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [dapid_pkg::CSR_DW-1:0]   csr_pwdata,
   input  logic [dapid_pkg::CSR_DW-1:0]   csr_prdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             due_count
);
   import dapid_pkg::*;

   localparam int     LOOP_HZ    = 50;
   localparam longint PI_RAD_Q29 = 64'sd1686629713;
   localparam longint INTEG_MAX  = 64'sd65536;
   localparam longint DRIVE_MAX  = 64'sd2147483647;
   localparam longint DRIVE_MIN  = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] roll;
      logic signed [31:0] yaw;
   } drive_pair_type;

   drive_pair_type drives_due[$];

   logic signed [15:0] gain [6];
   logic [14:0]        roll_band, yaw_band;
   logic signed [15:0] roll_meas, yaw_meas, roll_ref, yaw_ref;
   logic [2:0]         seen;
   longint             roll_integ, yaw_integ, roll_prev, yaw_prev;
   int                 mismatches = 0;

   assign fail_count = mismatches;

   // binary angle to radians Q16, round half up
   function automatic longint angle_to_rad(longint e);
      return (e * PI_RAD_Q29 + (64'sd1 <<< 27)) >>> 28;
   endfunction

   function automatic longint next_integral(longint integ, longint e);
      longint s;
      s = integ + (e * PI_RAD_Q29) / (longint'(LOOP_HZ) <<< 28);
      if (s > INTEG_MAX) s = INTEG_MAX;
      if (s < -INTEG_MAX) s = -INTEG_MAX;
      return s;
   endfunction

   function automatic longint pid_sum(longint e, longint integ, longint prev,
                                      longint kp, longint ki, longint kd);
      return ((kp * angle_to_rad(e)) >>> 12) + ((ki * integ) >>> 12)
           + ((kd * angle_to_rad(e - prev) * LOOP_HZ) >>> 12);
   endfunction

   function automatic logic signed [31:0] weigh_drive(longint e, longint band, longint v);
      longint mag, r;
      mag = (e < 0) ? -e : e;
      r = 0;
      if (mag > band) r = (2 * mag > 3 * band) ? 2 * v : v;
      if (r > DRIVE_MAX) r = DRIVE_MAX;
      if (r < DRIVE_MIN) r = DRIVE_MIN;
      return r[31:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      drive_pair_type     due;
      logic signed [31:0] got_roll, got_yaw;
      logic signed [15:0] roll_err, yaw_err;
      longint             roll_sum, yaw_sum;
      reg_type            slot;
      cmd_type            cmd;
      if (reset) begin
         gain[REG_ROLL_P] = ROLL_P_RST;
         gain[REG_ROLL_I] = ROLL_I_RST;
         gain[REG_ROLL_D] = ROLL_D_RST;
         gain[REG_YAW_P]  = YAW_P_RST;
         gain[REG_YAW_I]  = YAW_I_RST;
         gain[REG_YAW_D]  = YAW_D_RST;
         roll_band  = ROLL_TOL_RST;
         yaw_band   = YAW_TOL_RST;
         roll_meas  = '0;
         yaw_meas   = '0;
         roll_ref   = '0;
         yaw_ref    = '0;
         seen       = '0;
         roll_integ = 0;
         yaw_integ  = 0;
         roll_prev  = 0;
         yaw_prev   = 0;
         drives_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            slot = reg_type'(csr_paddr[4:2]);
            if (csr_pwrite) begin
               if (slot == REG_ROLL_TOL)
                  roll_band = csr_pwdata[14:0];
               else if (slot == REG_YAW_TOL)
                  yaw_band = csr_pwdata[14:0];
               else
                  gain[slot] = csr_pwdata[15:0];
            end else if (slot == REG_ROLL_TOL || slot == REG_YAW_TOL) begin
               if (csr_prdata[14:0] != ((slot == REG_ROLL_TOL) ? roll_band : yaw_band))
                  report_mismatch($sformatf("register %s read back %0d", slot.name(),
                                            csr_prdata[14:0]));
            end else if (csr_prdata[15:0] != gain[slot]) begin
               report_mismatch($sformatf("register %s read back %0d expected %0d",
                                         slot.name(), $signed(csr_prdata[15:0]),
                                         gain[slot]));
            end
         end

         // retire the oldest expectation before any new one is queued
         if (rsp_tvalid && rsp_tready) begin
            got_roll = rsp_tdata[31:0];
            got_yaw  = rsp_tdata[63:32];
            if (drives_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result roll %0d yaw %0d",
                                         got_roll, got_yaw));
            end else begin
               due = drives_due.pop_front();
               if (got_roll != due.roll)
                  report_mismatch($sformatf("roll_drive %0d expected %0d",
                                            got_roll, due.roll));
               if (got_yaw != due.yaw)
                  report_mismatch($sformatf("yaw_drive %0d expected %0d",
                                            got_yaw, due.yaw));
            end
         end

         if (req_tvalid && req_tready) begin
            cmd = cmd_type'(req_tuser);
            case (cmd)
               CMD_ROLL: begin
                  roll_meas = req_tdata[15:0];
                  seen[0] = 1'b1;
               end
               CMD_YAW: begin
                  yaw_meas = req_tdata[15:0];
                  seen[1] = 1'b1;
               end
               CMD_REF: begin
                  roll_ref = req_tdata[15:0];
                  yaw_ref  = req_tdata[31:16];
                  seen[2] = 1'b1;
               end
               default: begin
                  if (seen == 3'b111) begin
                     roll_err   = roll_ref - roll_meas;
                     yaw_err    = yaw_ref - yaw_meas;
                     roll_integ = next_integral(roll_integ, roll_err);
                     yaw_integ  = next_integral(yaw_integ, yaw_err);
                     roll_sum   = pid_sum(roll_err, roll_integ, roll_prev, gain[REG_ROLL_P],
                                          gain[REG_ROLL_I], gain[REG_ROLL_D]);
                     yaw_sum    = pid_sum(yaw_err, yaw_integ, yaw_prev, gain[REG_YAW_P],
                                          gain[REG_YAW_I], gain[REG_YAW_D]);
                     roll_prev  = roll_err;
                     yaw_prev   = yaw_err;
                     due.roll   = weigh_drive(roll_err, roll_band, roll_sum);
                     due.yaw    = weigh_drive(yaw_err, yaw_band, yaw_sum);
                     drives_due.push_back(due);
                  end
               end
            endcase
         end
      end
      due_count = drives_due.size();
   end

endmodule

FILE: tb/tb_top.sv
// Top of the dual-axis PID testbench: clock, reset, register set-up, request stimulus
// and result back-pressure. Depends on dapid_pkg, the block and pid_drive_checker.
`timescale 1ns / 1ps

module tb_top;
   import dapid_pkg::*;

   localparam int ITEMS_PER_PHASE = 215;
   localparam int PHASES          = 8;
   localparam int SETTLE_CYCLES   = 32;
   localparam int LIMIT_CYCLES    = 700_000;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata   = '0;
   logic [1:0]          req_tuser   = CMD_ROLL;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [63:0]         rsp_tdata;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   int                  fail_count;
   int                  due_count;

   logic                req_calm = 1'b0;
   logic                rsp_calm = 1'b0;
   logic [15:0]         roll_aim = '0;
   logic [15:0]         yaw_aim  = '0;
   int                  roll_window = ROLL_TOL_RST;
   int                  yaw_window  = YAW_TOL_RST;

   dual_axis_pid_with_error_weighting_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pid_drive_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .due_count   (due_count)
   );

   always #6 clock = ~clock;

   initial begin : run_limit
      #(LIMIT_CYCLES * 12);
      $display("dual_axis_pid_with_error_weighting_top regression: fail");
      $finish;
   end

   // result side: unless calm, stall a random number of cycles before each transaction
   initial begin : result_sink
      int hold;
      forever begin
         hold = rsp_calm ? 0 : $urandom_range(0, 7);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_event(input cmd_type cmd, input logic [15:0] a, input logic [15:0] b);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {b, a};
      if (cmd == CMD_REF) begin
         roll_aim = a;
         yaw_aim  = b;
      end
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic csr_access(input reg_type slot, input logic wr, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {slot, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   // hold until every expected result is back, then let the block go quiet
   task automatic settle();
      while (due_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_setup(input int kp_r, input int ki_r, input int kd_r,
                             input int kp_y, input int ki_y, input int kd_y,
                             input int tol_r, input int tol_y);
      csr_access(REG_ROLL_P, 1'b1, 16'(kp_r));
      csr_access(REG_ROLL_I, 1'b1, 16'(ki_r));
      csr_access(REG_ROLL_D, 1'b1, 16'(kd_r));
      csr_access(REG_YAW_P, 1'b1, 16'(kp_y));
      csr_access(REG_YAW_I, 1'b1, 16'(ki_y));
      csr_access(REG_YAW_D, 1'b1, 16'(kd_y));
      // bit 15 of a tolerance is not stored
      csr_access(REG_ROLL_TOL, 1'b1, {1'($urandom), 15'(tol_r)});
      csr_access(REG_YAW_TOL, 1'b1, {1'($urandom), 15'(tol_y)});
      for (int i = 0; i < 8; i++)
         csr_access(reg_type'(i), 1'b0, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      roll_window = tol_r;
      yaw_window  = tol_y;
      @(negedge clock);
   endtask

   function automatic int pick_gain();
      if ($urandom_range(0, 2) == 0)
         return int'($urandom_range(0, 65535)) - 32768;
      return int'($urandom_range(0, 8191)) - 4096;
   endfunction

   function automatic int pick_tol();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 32767);
      return $urandom_range(0, 3000);
   endfunction

   // measurement mostly close to the reference, else random, so that all three weights turn up
   function automatic logic [15:0] near_angle(input logic [15:0] aim, input int band);
      int span, off;
      if ($urandom_range(0, 9) < 4)
         return 16'($urandom);
      span = 2 * band + 8;
      off  = int'($urandom_range(0, span)) - band - 4;
      return aim - 16'(off);
   endfunction

   task automatic random_event(inout int sent);
      int pick, burst;
      logic [15:0] a, b;
      if ($urandom_range(0, 39) == 0) begin
         req_calm = ($urandom_range(0, 2) == 0);
         rsp_calm = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      b = 16'($urandom);
      if (pick < 22) begin
         send_event(CMD_ROLL, near_angle(roll_aim, roll_window), b);
         sent++;
      end else if (pick < 44) begin
         send_event(CMD_YAW, near_angle(yaw_aim, yaw_window), b);
         sent++;
      end else if (pick < 60) begin
         a = 16'($urandom);
         if ($urandom_range(0, 9) == 0) begin
            a = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            b = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         end
         send_event(CMD_REF, a, b);
         sent++;
      end else if (pick < 96) begin
         send_event(CMD_TICK, 16'($urandom), b);
         sent++;
      end else begin
         // run of ticks on a held error: drive the integrator toward its clamp
         burst = $urandom_range(10, 24);
         repeat (burst) send_event(CMD_TICK, 16'($urandom), 16'($urandom));
         sent += burst;
      end
   endtask

   initial begin : stimulus
      int sent;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ticks stay silent until roll, yaw and reference have all arrived
      send_event(CMD_TICK, 16'h1234, 16'h4321);
      send_event(CMD_ROLL, 16'h7fff, 16'hffff);
      send_event(CMD_TICK, 16'h0000, 16'h0000);
      send_event(CMD_YAW, 16'h8000, 16'h5a5a);
      send_event(CMD_TICK, 16'hffff, 16'hffff);
      send_event(CMD_REF, 16'h8000, 16'h7fff);
      send_event(CMD_TICK, 16'h0000, 16'h0000);
      send_event(CMD_ROLL, 16'h0000, 16'ha5a5);
      send_event(CMD_YAW, 16'h0000, 16'h0000);
      send_event(CMD_REF, 16'h0000, 16'h0000);
      send_event(CMD_TICK, 16'h0000, 16'h0000);
      // errors at, just past, and around one and a half times the dead band
      send_event(CMD_REF, 16'd522, -16'sd907);
      send_event(CMD_TICK, 16'h0000, 16'h0000);
      send_event(CMD_REF, 16'd523, 16'd908);
      send_event(CMD_TICK, 16'h0000, 16'h0000);
      send_event(CMD_REF, 16'd783, -16'sd1360);
      send_event(CMD_TICK, 16'h0000, 16'h0000);
      send_event(CMD_REF, 16'd784, 16'd1361);
      send_event(CMD_TICK, 16'h0000, 16'h0000);
      send_event(CMD_REF, 16'h7fff, 16'h8000);
      send_event(CMD_TICK, 16'h0000, 16'h0000);
      send_event(CMD_REF, 16'h8000, 16'h7fff);
      send_event(CMD_TICK, 16'hffff, 16'hffff);
      req_tvalid <= 1'b0;
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: ;
            1: load_setup(32767, 32767, 32767, 32767, 32767, 32767, 0, 0);
            2: load_setup(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767);
            3: load_setup(0, 0, 0, 0, 0, 0, pick_tol(), pick_tol());
            4: load_setup(ROLL_P_RST, ROLL_I_RST, ROLL_D_RST, YAW_P_RST, YAW_I_RST,
                          YAW_D_RST, pick_tol(), pick_tol());
            default: load_setup(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                                pick_gain(), pick_gain(), pick_tol(), pick_tol());
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) random_event(sent);
         req_tvalid <= 1'b0;
         settle();
      end

      if (fail_count == 0)
         $display("dual_axis_pid_with_error_weighting_top regression: pass");
      else
         $display("dual_axis_pid_with_error_weighting_top regression: fail");
      $finish;
   end

endmodule

FILE: dual_axis_pid_with_error_weighting_top.f
design/dapid_pkg.sv
design/dapid_core.sv
design/dual_axis_pid_with_error_weighting_top.sv
tb/pid_drive_checker.sv
tb/tb_top.sv
